FILE: design/frfg_pkg.sv
// Shared definitions for the frame rate fallback governor.
// Holds item and finish codes, register indexes and reset values.
// No dependencies.
package frfg_pkg;

	localparam int RATE_W    = 6;
	localparam int BUDGET_W  = 10;
	localparam int OVLIM_W   = 8;
	localparam int RUN_W     = 16;
	localparam int COUNT_W   = 32;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [RATE_W-1:0]   TARGET_RATE_RST     = 6'd20;
	localparam logic [RATE_W-1:0]   FALLBACK_RATE_RST   = 6'd15;
	localparam logic [BUDGET_W-1:0] TARGET_BUDGET_RST   = 10'd50;
	localparam logic [BUDGET_W-1:0] FALLBACK_BUDGET_RST = 10'd66;
	localparam logic [OVLIM_W-1:0]  OVERRUN_LIMIT_RST   = 8'd5;
	localparam logic [RUN_W-1:0]    RECOVER_LIMIT_RST   = 16'd100;

	localparam int MS_PER_S_W = 10;
	localparam logic [MS_PER_S_W-1:0] MS_PER_S = 10'd1000;

	typedef enum logic [1:0] {
		MODE_FRAME     = 2'd0,
		MODE_REC_START = 2'd1,
		MODE_REC_STOP  = 2'd2,
		MODE_STREAM    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FIN_NONE       = 2'd0,
		FIN_DURATION   = 2'd1,
		FIN_STOPPED    = 2'd2,
		FIN_STORE_FAIL = 2'd3
	} finish_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_RATE     = 3'd0,
		CFG_FALLBACK_RATE   = 3'd1,
		CFG_TARGET_BUDGET   = 3'd2,
		CFG_FALLBACK_BUDGET = 3'd3,
		CFG_OVERRUN_LIMIT   = 3'd4,
		CFG_RECOVER_LIMIT   = 3'd5
	} cfg_idx_t;

endpackage

FILE: design/frame_rate_fallback_governor.sv
// Top level of the frame rate fallback governor: input register, state update and result register.
// Depends on frfg_pkg.
//
// One transaction in gives one result transaction out. Items are accepted one per cycle unless
// the result stalls: an input register holds the item, the state update and result are computed
// from it and loaded into the result register together with the new state, so the next item
// may follow immediately. The duration of a recording is converted to milliseconds once, at
// record start, by a single 32 by 10 bit multiply; frame outcomes then only subtract and
// compare timestamps. Both stages stall only when a result is waiting and out_ready is low.
// Configuration writes take effect at the clock edge of cfg_we.
module frame_rate_fallback_governor (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_we,
	input  logic [frfg_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [frfg_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic                               captured,
	input  logic [15:0]                        frame_time,
	input  logic                               queued,
	input  logic                               store_ok,
	input  logic                               enable,
	input  logic [frfg_pkg::TIME_W-1:0]        duration_s,
	input  logic [frfg_pkg::TIME_W-1:0]        now_ms,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [frfg_pkg::RATE_W-1:0]        rate_now,
	output logic                               stream_on,
	output logic                               record_on,
	output logic                               accepted,
	output logic [1:0]                         finish_code,
	output logic [frfg_pkg::COUNT_W-1:0]       frames_recorded,
	output logic [frfg_pkg::COUNT_W-1:0]       frames_dropped
);

	localparam int RUN_W   = frfg_pkg::RUN_W;
	localparam int COUNT_W = frfg_pkg::COUNT_W;
	localparam int TIME_W  = frfg_pkg::TIME_W;
	localparam int PROD_W  = TIME_W + frfg_pkg::MS_PER_S_W;

	// Configuration registers.
	logic [frfg_pkg::RATE_W-1:0]   target_rate_q, fallback_rate_q;
	logic [frfg_pkg::BUDGET_W-1:0] target_budget_q, fallback_budget_q;
	logic [frfg_pkg::OVLIM_W-1:0]  overrun_limit_q;
	logic [RUN_W-1:0]              recover_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_rate_q     <= frfg_pkg::TARGET_RATE_RST;
			fallback_rate_q   <= frfg_pkg::FALLBACK_RATE_RST;
			target_budget_q   <= frfg_pkg::TARGET_BUDGET_RST;
			fallback_budget_q <= frfg_pkg::FALLBACK_BUDGET_RST;
			overrun_limit_q   <= frfg_pkg::OVERRUN_LIMIT_RST;
			recover_limit_q   <= frfg_pkg::RECOVER_LIMIT_RST;
		end else if (cfg_we) begin
			case (frfg_pkg::cfg_idx_t'(cfg_addr))
				frfg_pkg::CFG_TARGET_RATE:     target_rate_q     <= cfg_data[frfg_pkg::RATE_W-1:0];
				frfg_pkg::CFG_FALLBACK_RATE:   fallback_rate_q   <= cfg_data[frfg_pkg::RATE_W-1:0];
				frfg_pkg::CFG_TARGET_BUDGET:   target_budget_q   <= cfg_data[frfg_pkg::BUDGET_W-1:0];
				frfg_pkg::CFG_FALLBACK_BUDGET: fallback_budget_q <= cfg_data[frfg_pkg::BUDGET_W-1:0];
				frfg_pkg::CFG_OVERRUN_LIMIT:   overrun_limit_q   <= cfg_data[frfg_pkg::OVLIM_W-1:0];
				frfg_pkg::CFG_RECOVER_LIMIT:   recover_limit_q   <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage.
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic              captured_s1, queued_s1, store_ok_s1, enable_s1;
	logic [15:0]       frame_time_s1;
	logic [TIME_W-1:0] duration_s1, now_s1;
	logic              out_load, advance_s1;

	assign out_load   = !out_valid || out_ready;
	assign advance_s1 = valid_s1 && out_load;
	assign in_ready   = !valid_s1 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1       <= mode;
			captured_s1   <= captured;
			frame_time_s1 <= frame_time;
			queued_s1     <= queued;
			store_ok_s1   <= store_ok;
			enable_s1     <= enable;
			duration_s1   <= duration_s;
			now_s1        <= now_ms;
		end
	end

	// Governor state. The record limit is kept in milliseconds, with a flag for limits that
	// can never be reached by a 32-bit elapsed time (including no limit at all).
	logic               streaming_q, recording_q, on_fallback_q;
	logic [RUN_W-1:0]   overrun_run_q, good_run_q;
	logic [COUNT_W-1:0] recorded_q, dropped_q;
	logic [TIME_W-1:0]  limit_ms_q, start_ms_q;
	logic               no_limit_q;

	logic               streaming_d, recording_d, on_fallback_d;
	logic [RUN_W-1:0]   overrun_run_d, good_run_d;
	logic [COUNT_W-1:0] recorded_d, dropped_d;
	logic [TIME_W-1:0]  limit_ms_d, start_ms_d;
	logic               no_limit_d;
	logic               accepted_d;
	frfg_pkg::finish_t  finish_d;

	logic [PROD_W-1:0]  duration_ms;
	logic [TIME_W-1:0]  elapsed;
	logic               expired, overrun, is_good;
	logic [frfg_pkg::BUDGET_W-1:0] budget;
	logic [RUN_W-1:0]   overrun_inc, good_inc;

	assign duration_ms = PROD_W'(duration_s1) * PROD_W'(frfg_pkg::MS_PER_S);
	assign elapsed     = now_s1 - start_ms_q;
	assign expired     = !no_limit_q && (elapsed >= limit_ms_q);
	assign budget      = (on_fallback_q && !recording_q) ? fallback_budget_q : target_budget_q;
	assign overrun_inc = (&overrun_run_q) ? overrun_run_q : overrun_run_q + 1'b1;
	assign good_inc    = (&good_run_q) ? good_run_q : good_run_q + 1'b1;

	always_comb begin
		streaming_d   = streaming_q;
		recording_d   = recording_q;
		on_fallback_d = on_fallback_q;
		overrun_run_d = overrun_run_q;
		good_run_d    = good_run_q;
		recorded_d    = recorded_q;
		dropped_d     = dropped_q;
		limit_ms_d    = limit_ms_q;
		start_ms_d    = start_ms_q;
		no_limit_d    = no_limit_q;
		accepted_d    = 1'b0;
		finish_d      = frfg_pkg::FIN_NONE;
		overrun       = 1'b0;
		is_good       = 1'b0;

		case (frfg_pkg::mode_t'(mode_s1))
			frfg_pkg::MODE_FRAME: begin
				if (recording_q) begin
					accepted_d = 1'b1;
					if (expired) begin
						recording_d = 1'b0;
						finish_d    = frfg_pkg::FIN_DURATION;
					end else begin
						if (captured_s1 && store_ok_s1) begin
							recorded_d = (&recorded_q) ? recorded_q : recorded_q + 1'b1;
						end else begin
							dropped_d = (&dropped_q) ? dropped_q : dropped_q + 1'b1;
						end
						on_fallback_d = 1'b0;
						overrun       = !captured_s1 || (frame_time_s1 > 16'(target_budget_q));
						is_good       = 1'b1;
						if (captured_s1 && !store_ok_s1) begin
							recording_d = 1'b0;
							finish_d    = frfg_pkg::FIN_STORE_FAIL;
						end
					end
				end else if (streaming_q) begin
					accepted_d = 1'b1;
					overrun    = !captured_s1 || (frame_time_s1 > 16'(budget)) || !queued_s1;
					is_good    = 1'b1;
				end

				// Run bookkeeping shared by recording and stream frames.
				if (is_good) begin
					overrun_run_d = overrun ? overrun_inc : '0;
					good_run_d    = overrun ? '0 : good_inc;
				end
				if (is_good && !recording_q) begin
					if (!on_fallback_q && (overrun_run_d >= RUN_W'(overrun_limit_q))) begin
						on_fallback_d = 1'b1;
						overrun_run_d = '0;
					end
					if (on_fallback_d && (good_run_d >= recover_limit_q)) begin
						on_fallback_d = 1'b0;
						good_run_d    = '0;
					end
				end
			end
			frfg_pkg::MODE_REC_START: begin
				if (!recording_q && store_ok_s1) begin
					accepted_d    = 1'b1;
					recording_d   = 1'b1;
					limit_ms_d    = duration_ms[TIME_W-1:0];
					no_limit_d    = (duration_s1 == '0) || (duration_ms[PROD_W-1:TIME_W] != '0);
					start_ms_d    = now_s1;
					recorded_d    = '0;
					dropped_d     = '0;
					on_fallback_d = 1'b0;
					overrun_run_d = '0;
					good_run_d    = '0;
				end
			end
			frfg_pkg::MODE_REC_STOP: begin
				if (recording_q) begin
					accepted_d  = 1'b1;
					recording_d = 1'b0;
					finish_d    = frfg_pkg::FIN_STOPPED;
				end
			end
			frfg_pkg::MODE_STREAM: begin
				accepted_d  = 1'b1;
				streaming_d = enable_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streaming_q   <= 1'b0;
			recording_q   <= 1'b0;
			on_fallback_q <= 1'b0;
			overrun_run_q <= '0;
			good_run_q    <= '0;
			recorded_q    <= '0;
			dropped_q     <= '0;
			limit_ms_q    <= '0;
			start_ms_q    <= '0;
			no_limit_q    <= 1'b1;
		end else if (advance_s1) begin
			streaming_q   <= streaming_d;
			recording_q   <= recording_d;
			on_fallback_q <= on_fallback_d;
			overrun_run_q <= overrun_run_d;
			good_run_q    <= good_run_d;
			recorded_q    <= recorded_d;
			dropped_q     <= dropped_d;
			limit_ms_q    <= limit_ms_d;
			start_ms_q    <= start_ms_d;
			no_limit_q    <= no_limit_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rate_now        <= (recording_d || !on_fallback_d) ? target_rate_q : fallback_rate_q;
			stream_on       <= streaming_d;
			record_on       <= recording_d;
			accepted        <= accepted_d;
			finish_code     <= finish_d;
			frames_recorded <= recorded_d;
			frames_dropped  <= dropped_d;
		end
	end

`ifndef SYNTHESIS
	// A transaction that ends a recording never reports the recording as still active.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(record_on && (finish_code != frfg_pkg::FIN_NONE)))
		else $error("finish code reported while recording is still active");

	// Recording pins the target rate, so the fallback flag stays clear throughout.
	assert property (@(posedge clk) disable iff (!arst_n)
		recording_q |-> !on_fallback_q)
		else $error("fallback flag set during a recording");

	// The overrun and good runs are never counting at the same time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!((overrun_run_q != '0) && (good_run_q != '0)))
		else $error("overrun and good runs both nonzero");

	// No new transaction is taken while both stages are full and the result is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while the pipeline is stalled");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for frame_rate_fallback_governor.
// Depends on frfg_pkg and the governor RTL. It predicts every result with its own state
// model, runs directed tests and then random traffic, and checks each result transaction in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		frfg_pkg::mode_t mode;
		logic        captured;
		logic [15:0] frame_time;
		logic        queued;
		logic        store_ok;
		logic        enable;
		logic [31:0] duration_s;
		logic [31:0] now_ms;
	} frame_item_t;

	typedef struct {
		logic [5:0]  rate;
		logic        stream_on;
		logic        record_on;
		logic        accepted;
		frfg_pkg::finish_t finish;
		logic [31:0] recorded;
		logic [31:0] dropped;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                            cfg_we;
	logic [frfg_pkg::CFG_IDX_W-1:0]  cfg_addr;
	logic [frfg_pkg::CFG_DATA_W-1:0] cfg_data;

	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic        captured;
	logic [15:0] frame_time;
	logic        queued;
	logic        store_ok;
	logic        enable;
	logic [31:0] duration_s;
	logic [31:0] now_ms;

	logic        out_valid;
	logic        out_ready;
	logic [5:0]  rate_now;
	logic        stream_on;
	logic        record_on;
	logic        accepted;
	logic [1:0]  finish_code;
	logic [31:0] frames_recorded;
	logic [31:0] frames_dropped;

	frame_rate_fallback_governor dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .captured(captured),
		.frame_time(frame_time), .queued(queued), .store_ok(store_ok), .enable(enable),
		.duration_s(duration_s), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready), .rate_now(rate_now),
		.stream_on(stream_on), .record_on(record_on), .accepted(accepted),
		.finish_code(finish_code), .frames_recorded(frames_recorded),
		.frames_dropped(frames_dropped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register copies used by the governor model.
	logic [5:0]  reg_target_rate     = frfg_pkg::TARGET_RATE_RST;
	logic [5:0]  reg_fallback_rate   = frfg_pkg::FALLBACK_RATE_RST;
	logic [9:0]  reg_target_budget   = frfg_pkg::TARGET_BUDGET_RST;
	logic [9:0]  reg_fallback_budget = frfg_pkg::FALLBACK_BUDGET_RST;
	logic [7:0]  reg_overrun_limit   = frfg_pkg::OVERRUN_LIMIT_RST;
	logic [15:0] reg_recover_limit   = frfg_pkg::RECOVER_LIMIT_RST;

	// Governor model state.
	logic        gov_streaming   = 1'b0;
	logic        gov_recording   = 1'b0;
	logic        gov_fallback    = 1'b0;
	logic [15:0] gov_overrun_run = '0;
	logic [15:0] gov_good_run    = '0;
	logic [31:0] gov_recorded    = '0;
	logic [31:0] gov_dropped     = '0;
	logic [31:0] gov_limit_s     = '0;
	logic [31:0] gov_start_ms    = '0;

	status_t     expected_status_q[$];
	int          fail_count  = 0;
	int          items_sent  = 0;
	bit          idle_on     = 1'b1;
	int          rx_hold     = 0;
	logic [31:0] wall_ms;

	function automatic void tally_run(input logic overrun);
		if (overrun) begin
			if (gov_overrun_run != 16'hFFFF)
				gov_overrun_run++;
			gov_good_run = '0;
		end else begin
			gov_overrun_run = '0;
			if (gov_good_run != 16'hFFFF)
				gov_good_run++;
		end
	endfunction

	function automatic status_t predict_status(input frame_item_t it);
		status_t     r;
		logic [31:0] elapsed;
		logic [63:0] limit_ms;
		logic [9:0]  budget;
		r.accepted = 1'b0;
		r.finish = frfg_pkg::FIN_NONE;
		case (it.mode)
			frfg_pkg::MODE_FRAME: begin
				if (gov_recording) begin
					elapsed = it.now_ms - gov_start_ms;
					limit_ms = 64'(gov_limit_s) * 64'd1000;
					r.accepted = 1'b1;
					if (gov_limit_s != 0 && {32'd0, elapsed} >= limit_ms) begin
						gov_recording = 1'b0;
						r.finish = frfg_pkg::FIN_DURATION;
					end else begin
						if (it.captured && it.store_ok) begin
							if (gov_recorded != '1)
								gov_recorded++;
						end else if (gov_dropped != '1) begin
							gov_dropped++;
						end
						gov_fallback = 1'b0;
						tally_run(!it.captured || it.frame_time > 16'(reg_target_budget));
						if (it.captured && !it.store_ok) begin
							gov_recording = 1'b0;
							r.finish = frfg_pkg::FIN_STORE_FAIL;
						end
					end
				end else if (gov_streaming) begin
					budget = gov_fallback ? reg_fallback_budget : reg_target_budget;
					r.accepted = 1'b1;
					tally_run(!it.captured || it.frame_time > 16'(budget) || !it.queued);
					if (!gov_fallback && gov_overrun_run >= 16'(reg_overrun_limit)) begin
						gov_fallback = 1'b1;
						gov_overrun_run = '0;
					end
					if (gov_fallback && gov_good_run >= reg_recover_limit) begin
						gov_fallback = 1'b0;
						gov_good_run = '0;
					end
				end
			end
			frfg_pkg::MODE_REC_START: begin
				if (!gov_recording && it.store_ok) begin
					r.accepted = 1'b1;
					gov_recording = 1'b1;
					gov_limit_s = it.duration_s;
					gov_start_ms = it.now_ms;
					gov_recorded = '0;
					gov_dropped = '0;
					gov_fallback = 1'b0;
					gov_overrun_run = '0;
					gov_good_run = '0;
				end
			end
			frfg_pkg::MODE_REC_STOP: begin
				if (gov_recording) begin
					r.accepted = 1'b1;
					gov_recording = 1'b0;
					r.finish = frfg_pkg::FIN_STOPPED;
				end
			end
			default: begin
				r.accepted = 1'b1;
				gov_streaming = it.enable;
			end
		endcase
		r.rate = (gov_recording || !gov_fallback) ? reg_target_rate : reg_fallback_rate;
		r.stream_on = gov_streaming;
		r.record_on = gov_recording;
		r.recorded = gov_recorded;
		r.dropped = gov_dropped;
		return r;
	endfunction

	// Fields that a given kind of item ignores are left random.
	function automatic frame_item_t rand_item();
		frame_item_t it;
		it.mode = frfg_pkg::mode_t'($urandom_range(0, 3));
		it.captured = 1'($urandom());
		it.frame_time = 16'($urandom());
		it.queued = 1'($urandom());
		it.store_ok = 1'($urandom());
		it.enable = 1'($urandom());
		it.duration_s = $urandom();
		it.now_ms = $urandom();
		return it;
	endfunction

	function automatic frame_item_t mk_frame(input logic cap, input logic [15:0] ms,
			input logic q, input logic ok, input logic [31:0] t);
		frame_item_t it;
		it = rand_item();
		it.mode = frfg_pkg::MODE_FRAME;
		it.captured = cap;
		it.frame_time = ms;
		it.queued = q;
		it.store_ok = ok;
		it.now_ms = t;
		return it;
	endfunction

	function automatic frame_item_t mk_start(input logic ok, input logic [31:0] dur,
			input logic [31:0] t);
		frame_item_t it;
		it = rand_item();
		it.mode = frfg_pkg::MODE_REC_START;
		it.store_ok = ok;
		it.duration_s = dur;
		it.now_ms = t;
		return it;
	endfunction

	function automatic frame_item_t mk_stop(input logic [31:0] t);
		frame_item_t it;
		it = rand_item();
		it.mode = frfg_pkg::MODE_REC_STOP;
		it.now_ms = t;
		return it;
	endfunction

	function automatic frame_item_t mk_stream(input logic en, input logic [31:0] t);
		frame_item_t it;
		it = rand_item();
		it.mode = frfg_pkg::MODE_STREAM;
		it.enable = en;
		it.now_ms = t;
		return it;
	endfunction

	function automatic logic likely(input int n);
		return $urandom_range(0, n - 1) != 0;
	endfunction

	// Frame times cluster around the budget that currently applies.
	function automatic logic [15:0] pick_ms();
		logic [15:0] b;
		b = 16'((gov_fallback && !gov_recording) ? reg_fallback_budget : reg_target_budget);
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return b - 16'(b != 0);
			2: return b;
			3: return b + 16'd1;
			6: return 16'($urandom());
			7: return 16'hFFFF;
			default: return 16'($urandom_range(0, 2 * int'(b) + 2));
		endcase
	endfunction

	task automatic send_item(input frame_item_t it);
		logic    rdy;
		status_t want;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= it.mode;
		captured   <= it.captured;
		frame_time <= it.frame_time;
		queued     <= it.queued;
		store_ok   <= it.store_ok;
		enable     <= it.enable;
		duration_s <= it.duration_s;
		now_ms     <= it.now_ms;
		// Ready is sampled at the falling edge, where it is stable for the next rising edge.
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		want = predict_status(it);
		expected_status_q.push_back(want);
		items_sent++;
	endtask

	task automatic put_reg(input frfg_pkg::cfg_idx_t idx, input logic [15:0] data);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			frfg_pkg::CFG_TARGET_RATE:     reg_target_rate = data[5:0];
			frfg_pkg::CFG_FALLBACK_RATE:   reg_fallback_rate = data[5:0];
			frfg_pkg::CFG_TARGET_BUDGET:   reg_target_budget = data[9:0];
			frfg_pkg::CFG_FALLBACK_BUDGET: reg_fallback_budget = data[9:0];
			frfg_pkg::CFG_OVERRUN_LIMIT:   reg_overrun_limit = data[7:0];
			frfg_pkg::CFG_RECOVER_LIMIT:   reg_recover_limit = data;
			default: ;
		endcase
	endtask

	// Registers are only written once every result transaction has come back.
	task automatic program_regs(input logic [15:0] trate, input logic [15:0] frate,
			input logic [15:0] tbud, input logic [15:0] fbud,
			input logic [15:0] olim, input logic [15:0] rlim);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		put_reg(frfg_pkg::CFG_TARGET_RATE, trate);
		put_reg(frfg_pkg::CFG_FALLBACK_RATE, frate);
		put_reg(frfg_pkg::CFG_TARGET_BUDGET, tbud);
		put_reg(frfg_pkg::CFG_FALLBACK_BUDGET, fbud);
		put_reg(frfg_pkg::CFG_OVERRUN_LIMIT, olim);
		put_reg(frfg_pkg::CFG_RECOVER_LIMIT, rlim);
		cfg_we <= 1'b0;
	endtask

	task automatic test_idle_commands();
		send_item(mk_frame(1'b1, 16'd10, 1'b1, 1'b1, 32'd100));
		send_item(mk_stop(32'd110));
		send_item(mk_start(1'b0, 32'd3, 32'd120));
	endtask

	task automatic test_stream_fallback();
		send_item(mk_stream(1'b1, 32'd200));
		send_item(mk_frame(1'b0, 16'd10, 1'b1, 1'b1, 32'd210));
		send_item(mk_frame(1'b1, 16'd51, 1'b1, 1'b1, 32'd220));
		send_item(mk_frame(1'b1, 16'd10, 1'b0, 1'b1, 32'd230));
		send_item(mk_frame(1'b1, 16'hFFFF, 1'b1, 1'b1, 32'd240));
		send_item(mk_frame(1'b1, 16'd50, 1'b0, 1'b0, 32'd250));
		// A frame exactly at the fallback budget counts as good.
		send_item(mk_frame(1'b1, 16'd66, 1'b1, 1'b1, 32'd260));
	endtask

	task automatic test_record_session();
		send_item(mk_start(1'b1, 32'd0, 32'h0000_1000));
		send_item(mk_start(1'b1, 32'd5, 32'h0000_1010));
		send_item(mk_frame(1'b1, 16'd50, 1'b0, 1'b1, 32'h0000_1020));
		send_item(mk_frame(1'b0, 16'd0, 1'b1, 1'b1, 32'h0000_1030));
		send_item(mk_stop(32'h0000_1040));
		send_item(mk_stop(32'h0000_1050));
	endtask

	task automatic test_record_endings();
		logic [31:0] t0;
		t0 = 32'hFFFF_FC18;
		// Expiry is measured across the wrap of the millisecond clock.
		send_item(mk_start(1'b1, 32'd2, t0));
		send_item(mk_frame(1'b1, 16'd10, 1'b1, 1'b1, t0 + 32'd1999));
		send_item(mk_frame(1'b1, 16'd10, 1'b1, 1'b1, t0 + 32'd2000));
		send_item(mk_start(1'b1, 32'd0, 32'h1234));
		send_item(mk_frame(1'b1, 16'd10, 1'b1, 1'b0, 32'h1300));
		// This limit lies beyond any 32-bit elapsed time.
		send_item(mk_start(1'b1, 32'd4294968, 32'h10));
		send_item(mk_frame(1'b0, 16'd0, 1'b0, 1'b1, 32'h0F));
		send_item(mk_stop(32'h20));
		send_item(mk_stream(1'b0, 32'h30));
		send_item(mk_frame(1'b1, 16'd5, 1'b1, 1'b1, 32'h40));
	endtask

	task automatic test_zero_limits();
		// Values wider than a register are cut to its width.
		program_regs(16'hFFC0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFF00, 16'h0000);
		send_item(mk_stream(1'b1, 32'd500));
		send_item(mk_frame(1'b1, 16'd0, 1'b1, 1'b1, 32'd510));
		send_item(mk_frame(1'b1, 16'd1, 1'b1, 1'b1, 32'd520));
		program_regs(16'd1, 16'd60, 16'd1, 16'd1000, 16'd0, 16'hFFFF);
		send_item(mk_frame(1'b1, 16'd0, 1'b1, 1'b1, 32'd530));
		send_item(mk_frame(1'b1, 16'd1000, 1'b1, 1'b1, 32'd540));
		send_item(mk_start(1'b1, 32'd0, 32'd550));
		send_item(mk_stop(32'd560));
	endtask

	task automatic test_output_stall();
		rx_hold = 60;
		repeat (40) begin
			wall_ms += 32'd30;
			send_item(mk_frame(likely(4), pick_ms(), likely(4), 1'b1, wall_ms));
		end
	endtask

	task automatic run_random(input int n);
		int          stop_at;
		int          len;
		logic [31:0] dur;
		logic [31:0] t_start;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					if ($urandom_range(0, 9) == 0)
						wall_ms = $urandom();
					if (!gov_streaming || $urandom_range(0, 7) == 0)
						send_item(mk_stream(likely(8), wall_ms));
					len = $urandom_range(3, 30);
					repeat (len) begin
						wall_ms += 32'($urandom_range(0, 200));
						send_item(mk_frame(likely(10), pick_ms(), likely(8),
							1'($urandom()), wall_ms));
					end
				end
				6, 7, 8: begin
					case ($urandom_range(0, 5))
						0: dur = 32'd0;
						1: dur = $urandom();
						default: dur = 32'($urandom_range(1, 3));
					endcase
					t_start = wall_ms;
					send_item(mk_start(likely(10), dur, t_start));
					len = $urandom_range(2, 20);
					repeat (len) begin
						wall_ms += 32'($urandom_range(0, 600));
						// Now and then land on or just short of the expiry point.
						if (dur != 0 && dur <= 3 && $urandom_range(0, 7) == 0)
							wall_ms = t_start + dur * 32'd1000 - 32'($urandom_range(0, 1));
						send_item(mk_frame(likely(10), pick_ms(), 1'($urandom()),
							likely(20), wall_ms));
					end
					if ($urandom_range(0, 2) != 0)
						send_item(mk_stop(wall_ms));
				end
				default: repeat ($urandom_range(1, 4)) send_item(rand_item());
			endcase
		end
	endtask

	task automatic test_random_traffic();
		program_regs(16'd20, 16'd15, 16'd50, 16'd66, 16'd5, 16'd100);
		run_random(145);
		program_regs(16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
			16'($urandom_range(20, 80)), 16'($urandom_range(30, 120)),
			16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)));
		run_random(145);
		program_regs(16'd60, 16'd60, 16'd1000, 16'd1000, 16'd255, 16'd65535);
		run_random(145);
		program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_random(145);
		idle_on = 1'b0;
		program_regs(16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
			16'($urandom_range(10, 200)), 16'($urandom_range(10, 200)),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)));
		run_random(145);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Each result transaction is taken at the rising edge after the falling edge that sees it.
	initial begin : result_check
		status_t want;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
				if (expected_status_q.size() == 0) begin
					fail_count++;
					$error("result transaction with no expected result waiting");
				end else begin
					want = expected_status_q.pop_front();
					check_field("rate_now", 32'(want.rate), 32'(rate_now));
					check_field("stream_on", 32'(want.stream_on), 32'(stream_on));
					check_field("record_on", 32'(want.record_on), 32'(record_on));
					check_field("accepted", 32'(want.accepted), 32'(accepted));
					check_field("finish_code", 32'(want.finish), 32'(finish_code));
					check_field("frames_recorded", want.recorded, frames_recorded);
					check_field("frames_dropped", want.dropped, frames_dropped);
				end
			end
		end
	end

	initial begin : result_ready
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 8) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_addr   <= frfg_pkg::CFG_TARGET_RATE;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		mode       <= frfg_pkg::MODE_FRAME;
		captured   <= 1'b0;
		frame_time <= '0;
		queued     <= 1'b0;
		store_ok   <= 1'b0;
		enable     <= 1'b0;
		duration_s <= '0;
		now_ms     <= '0;
		wall_ms = $urandom();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_commands();
		test_stream_fallback();
		test_record_session();
		test_record_endings();
		test_zero_limits();
		test_output_stall();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
